// ===== hdl/depth_first_path_search_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the depth-first path search block.
// Wraps concurrent assertions on a clock and an active-low synchronous reset.
// ---------------------------------------------------------------------------
`ifndef DEPTH_FIRST_PATH_SEARCH_TOP_ASSERT_SVH
`define DEPTH_FIRST_PATH_SEARCH_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DFPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dfps: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define DFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dfps: next-cycle check failed");

`endif

// ===== hdl/dfps_pkg.sv =====
// ---------------------------------------------------------------------------
// dfps_pkg
// Shared types, constants and the control store of the path search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfps_pkg;

    localparam int NODE_W             = 4;
    localparam int ROW_W              = 16;
    localparam int COUNT_W            = 5;
    localparam int NODE_SLOTS         = 16;
    localparam int DEF_MAX_NODE_COUNT = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [NODE_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] target_node;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              reached;
        logic              last;
    } t_result;

    localparam int UPC_W = 3;

    typedef logic [2:0] t_act;
    localparam t_act A_NONE   = 3'd0;
    localparam t_act A_LATCH  = 3'd1;
    localparam t_act A_INIT   = 3'd2;
    localparam t_act A_READ   = 3'd3;
    localparam t_act A_STEP   = 3'd4;
    localparam t_act A_FINISH = 3'd5;
    localparam t_act A_LOAD   = 3'd6;

    typedef logic [2:0] t_cond;
    localparam t_cond C_ALWAYS    = 3'd0;
    localparam t_cond C_NOT_START = 3'd1;
    localparam t_cond C_IS_LOAD   = 3'd2;
    localparam t_cond C_START_OOR = 3'd3;
    localparam t_cond C_HIT       = 3'd4;
    localparam t_cond C_CONT      = 3'd5;

    localparam logic [UPC_W-1:0] U_IDLE     = 3'd0;
    localparam logic [UPC_W-1:0] U_DISPATCH = 3'd1;
    localparam logic [UPC_W-1:0] U_INIT     = 3'd2;
    localparam logic [UPC_W-1:0] U_CHECK    = 3'd3;
    localparam logic [UPC_W-1:0] U_READ     = 3'd4;
    localparam logic [UPC_W-1:0] U_STEP     = 3'd5;
    localparam logic [UPC_W-1:0] U_FINISH   = 3'd6;
    localparam logic [UPC_W-1:0] U_LOAD     = 3'd7;

    typedef struct packed {
        t_act             act;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic is_load;
        logic start_oor;
        logic hit;
        logic cont;
    } t_flags;

    // A taken jump goes to the target; otherwise the program falls through.
    function automatic t_uword uc_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        unique case (addr)
            U_IDLE:     w = '{act: A_LATCH,  cond: C_NOT_START, target: U_IDLE};
            U_DISPATCH: w = '{act: A_NONE,   cond: C_IS_LOAD,   target: U_LOAD};
            U_INIT:     w = '{act: A_INIT,   cond: C_START_OOR, target: U_IDLE};
            U_CHECK:    w = '{act: A_NONE,   cond: C_HIT,       target: U_FINISH};
            U_READ:     w = '{act: A_READ,   cond: C_ALWAYS,    target: U_STEP};
            U_STEP:     w = '{act: A_STEP,   cond: C_CONT,      target: U_READ};
            U_FINISH:   w = '{act: A_FINISH, cond: C_ALWAYS,    target: U_IDLE};
            U_LOAD:     w = '{act: A_LOAD,   cond: C_ALWAYS,    target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/dfps_seq.sv =====
// ---------------------------------------------------------------------------
// dfps_seq
// Microprogram sequencer: step counter, control store and jump conditions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfps_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dfps_pkg::t_flags i_flags,
    output dfps_pkg::t_act  o_act,
    output logic            o_busy
);
    import dfps_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             take;

    assign uw = uc_rom(r_upc);

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_NOT_START: take = !i_start;
            C_IS_LOAD:   take = i_flags.is_load;
            C_START_OOR: take = i_flags.start_oor;
            C_HIT:       take = i_flags.hit;
            C_CONT:      take = i_flags.cont;
            default:     take = 1'b0;
        endcase
    end

    assign n_upc  = take ? uw.target : r_upc + UPC_W'(1);
    assign o_act  = (uw.act == A_LATCH && !i_start) ? A_NONE : uw.act;
    assign o_busy = (r_upc != U_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== hdl/dfps_dp.sv =====
// ---------------------------------------------------------------------------
// dfps_dp
// Search datapath: adjacency rows, path stack, visited marks and result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfps_dp #(
    parameter int MAX_NODE_COUNT = dfps_pkg::DEF_MAX_NODE_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dfps_pkg::t_act                 i_act,
    input  dfps_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic [dfps_pkg::COUNT_W-1:0]   i_cfg_data,
    output dfps_pkg::t_flags               o_flags,
    output logic                           o_result_strobe,
    output dfps_pkg::t_result              o_result
);
    import dfps_pkg::*;

    localparam int SLOTS = (MAX_NODE_COUNT < NODE_SLOTS) ? MAX_NODE_COUNT : NODE_SLOTS;
    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = $clog2(SLOTS + 1);
    localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(SLOTS);

    logic [COUNT_W-1:0] r_node_count;
    t_cmd               r_cmd;
    logic [SLOTS-1:0]   r_adj [SLOTS];
    logic [SW-1:0]      r_stack [SLOTS];
    logic [SLOTS-1:0]   r_visited;
    logic [DW-1:0]      r_depth;
    logic [SW-1:0]      r_top;
    logic [SLOTS-1:0]   r_row;
    logic [SW-1:0]      r_pend_node;
    logic               r_pend_hit;
    logic               r_out_valid;
    t_result            r_out;

    logic [COUNT_W-1:0] eff_n;
    logic [SLOTS-1:0]   in_use;
    logic [SLOTS-1:0]   cand;
    logic [SW-1:0]      pick;
    logic               pick_hit;
    logic               start_oor;
    logic               row_ok;
    logic [SW-1:0]      start_addr;
    logic [SW-1:0]      row_addr;
    logic [SW-1:0]      push_addr;
    logic [SW-1:0]      pop_addr;

    always_comb begin
        if (r_node_count == '0) begin
            eff_n = COUNT_W'(1);
        end else if (r_node_count > SLOTS_C) begin
            eff_n = SLOTS_C;
        end else begin
            eff_n = r_node_count;
        end
    end

    always_comb begin
        for (int v = 0; v < SLOTS; v++) begin
            in_use[v] = (COUNT_W'(v) < eff_n);
        end
    end

    assign cand = r_row & ~r_visited & in_use;

    always_comb begin
        pick = '0;
        for (int v = SLOTS - 1; v >= 0; v--) begin
            if (cand[v]) begin
                pick = SW'(v);
            end
        end
    end

    assign pick_hit   = (r_cmd.target_node == NODE_W'(pick));
    assign start_oor  = !(COUNT_W'(r_cmd.start_node) < eff_n);
    assign row_ok     = (COUNT_W'(r_cmd.row_index) < eff_n);
    assign start_addr = r_cmd.start_node[SW-1:0];
    assign row_addr   = r_cmd.row_index[SW-1:0];
    assign push_addr  = r_depth[SW-1:0];
    assign pop_addr   = SW'(r_depth - DW'(2));

    assign o_flags.is_load   = (r_cmd.operation == OP_LOAD);
    assign o_flags.start_oor = start_oor;
    assign o_flags.hit       = r_pend_hit;
    assign o_flags.cont      = (cand != '0) ? !pick_hit : (r_depth != DW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= COUNT_RESET;
            r_visited    <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            r_out_valid <= 1'b0;
            unique case (i_act)
                A_INIT: begin
                    if (start_oor) begin
                        r_visited <= '0;
                        r_depth   <= '0;
                    end else begin
                        r_visited <= SLOTS'(1) << start_addr;
                        r_depth   <= DW'(1);
                    end
                end
                A_STEP: begin
                    if (cand != '0) begin
                        r_visited   <= r_visited | (SLOTS'(1) << pick);
                        r_depth     <= r_depth + DW'(1);
                        r_out_valid <= 1'b1;
                    end else begin
                        r_depth <= r_depth - DW'(1);
                    end
                end
                A_FINISH: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_act)
            A_LATCH: begin
                r_cmd <= i_cmd;
            end
            A_LOAD: begin
                if (row_ok) begin
                    r_adj[row_addr] <= r_cmd.row_bits[SLOTS-1:0];
                end
            end
            A_INIT: begin
                r_stack[0]  <= start_addr;
                r_top       <= start_addr;
                r_pend_node <= start_addr;
                r_pend_hit  <= (r_cmd.target_node == r_cmd.start_node);
            end
            A_READ: begin
                r_row <= r_adj[r_top];
            end
            A_STEP: begin
                if (cand != '0) begin
                    r_stack[push_addr] <= pick;
                    r_top              <= pick;
                    r_out              <= '{node: NODE_W'(r_pend_node),
                                            reached: r_pend_hit, last: 1'b0};
                    r_pend_node        <= pick;
                    r_pend_hit         <= pick_hit;
                end else begin
                    r_top <= r_stack[pop_addr];
                end
            end
            A_FINISH: begin
                r_out <= '{node: NODE_W'(r_pend_node), reached: r_pend_hit, last: 1'b1};
            end
            default: begin
            end
        endcase
    end

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

endmodule

// ===== hdl/depth_first_path_search_top.sv =====
// ---------------------------------------------------------------------------
// depth_first_path_search_top
// Depth-first search over an adjacency matrix, run by a small microprogram.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Word
//  command   in         start high, busy low       i_cmd
//  result    out        o_result_strobe, 1 cycle   o_result
//  config    in         i_cfg_we                   i_cfg_data
//
//  A load passes through the dispatch and load steps, then busy falls.
//  A search runs dispatch, init and check steps of setup, then a read and
//  a push or pop step per pass of the control loop (at most 2n - 1 passes),
//  then a finish step issues the final word, unless start is out of range.
//  The loop rate is set by the registered read of the adjacency row.
//  Reset is synchronous; a clearing pass is not needed. Results cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_first_path_search_top_assert.svh"

module depth_first_path_search_top #(
    parameter int MAX_NODE_COUNT = dfps_pkg::DEF_MAX_NODE_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  dfps_pkg::t_cmd               i_cmd,
    input  logic                         i_cfg_we,
    input  logic [dfps_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                         o_result_strobe,
    output dfps_pkg::t_result            o_result
);
    import dfps_pkg::*;

    t_act   act;
    t_flags flags;

    dfps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_act   (act),
        .o_busy  (busy)
    );

    dfps_dp #(
        .MAX_NODE_COUNT (MAX_NODE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_act           (act),
        .i_cmd           (i_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_flags         (flags),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    `DFPS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `DFPS_ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_result_strobe && o_result.last, !busy)
    `DFPS_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_result_strobe && o_result.last, !o_result_strobe)

endmodule
